>>> rtl/priority_led_region_arbiter_unit_assert.svh
// Assertion macros used by the checker file of the LED region arbiter.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef PRIORITY_LED_REGION_ARBITER_UNIT_ASSERT_SVH
`define PRIORITY_LED_REGION_ARBITER_UNIT_ASSERT_SVH

// Checked on every rising edge outside reset.
`define PLRA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PLRA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/plra_pkg.sv
// Package for the LED region arbiter: field widths, defaults, codes and types.
// Used by plra_color_ram, priority_led_region_arbiter_unit and plra_checker.
package plra_pkg;

    // Default sizes of the arbiter.
    localparam int NUM_APPS_DEF    = 8;
    localparam int NUM_REGIONS_DEF = 8;

    // Field widths of the stream items.
    localparam int APP_W       = 3;
    localparam int MASK_W      = 8;
    localparam int REGION_W    = 4;
    localparam int COLOR_W     = 24;
    localparam int DREG_W      = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Driver presence register.
    localparam int                DRV_W     = 8;
    localparam logic [DRV_W-1:0]  DRV_RESET = 8'hFF;

    // Request kinds carried in the input tuser bit.
    localparam logic MODE_CLAIM = 1'b0;
    localparam logic MODE_COLOR = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_READ,
        S_LAST
    } t_state;

    // Access strobes toward the color memory.
    typedef struct packed {
        logic wr;
        logic rd;
    } t_ram_ctl;

endpackage

>>> rtl/plra_color_ram.sv
// Color cache memory: one 24-bit color per application and region, registered read.
// Depends on plra_pkg; clears itself with a sweep after reset.
module plra_color_ram #(
    parameter int ADDR_W = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  plra_pkg::t_ram_ctl           i_ctl,
    input  logic [ADDR_W-1:0]            i_addr,
    input  logic [plra_pkg::COLOR_W-1:0] i_wdata,
    output logic [plra_pkg::COLOR_W-1:0] o_rdata,
    output logic                         o_ready
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [plra_pkg::COLOR_W-1:0] r_mem [DEPTH];
    logic [plra_pkg::COLOR_W-1:0] r_rdata;
    logic [ADDR_W-1:0]            r_clr_addr;
    logic                         r_clearing;

    // Clearing sweep: one entry per cycle from address zero to the top.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == {ADDR_W{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Single write port shared by the sweep and the color updates.
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // Registered read; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_ready = !r_clearing;

endmodule

>>> rtl/priority_led_region_arbiter_unit.sv
// Channel  | Direction | tdata (low bit up)                          | tuser        | tlast
// s_axis   | in        | app, region_mask, region, color, zero pad   | mode         | -
// m_axis   | out       | drive_region, drive_color, grant_mask, pad  | drive_valid  | last
// cfg      | in        | i_cfg_wr_data = region_driver_present       | -            | -
//
// A color request (or one for an absent application) yields one result.
// A claim request walks the regions one per cycle, plus a color memory read (S_READ) for each
// redrive, then sends the closing result (S_LAST). Output stalls hold the walk in place.
// After reset the color memory (64 entries at the defaults) is cleared while s_axis_tready stays low.
// Depends on plra_pkg and plra_color_ram.
module priority_led_region_arbiter_unit #(
    parameter int NUM_APPS    = plra_pkg::NUM_APPS_DEF,
    parameter int NUM_REGIONS = plra_pkg::NUM_REGIONS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: app[2:0], region_mask[10:3], region[14:11], color[38:15], zero[39]
    input  logic [plra_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: mode
    input  logic                             s_axis_tuser,
    // Result stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: drive_region[2:0], drive_color[26:3], grant_mask[34:27], zero[39:35]
    output logic [plra_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: drive_valid
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast,
    // Configuration write.
    input  logic                             i_cfg_wr_en,
    input  logic [plra_pkg::DRV_W-1:0]       i_cfg_wr_data
);

    localparam int AW    = $clog2(NUM_APPS);
    localparam int RW    = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
    localparam int NR    = NUM_REGIONS;
    localparam int AXW   = (AW > plra_pkg::APP_W) ? AW : plra_pkg::APP_W;
    localparam int RXW   = (RW > plra_pkg::REGION_W) ? RW : plra_pkg::REGION_W;
    localparam int DXW   = (RW > plra_pkg::DREG_W) ? RW : plra_pkg::DREG_W;
    localparam int MXW   = (NR > plra_pkg::MASK_W) ? NR : plra_pkg::MASK_W;
    localparam int ADDR_W = AW + RW;

    // Registers.
    plra_pkg::t_state               r_state, n_state;
    logic [NR-1:0]                  r_claim [NUM_APPS];
    logic [NR-1:0]                  n_claim [NUM_APPS];
    logic [AW-1:0]                  r_app, n_app;
    logic [NR-1:0]                  r_changed, n_changed;
    logic [NR-1:0]                  r_grant, n_grant;
    logic [RW-1:0]                  r_region, n_region;
    logic [plra_pkg::DRV_W-1:0]     r_drv;
    logic                           r_out_valid, n_out_valid;
    logic                           r_out_user, n_out_user;
    logic [plra_pkg::DREG_W-1:0]    r_out_region, n_out_region;
    logic [plra_pkg::COLOR_W-1:0]   r_out_color, n_out_color;
    logic [plra_pkg::MASK_W-1:0]    r_out_grant, n_out_grant;
    logic                           r_out_last, n_out_last;

    // Input fields.
    logic [plra_pkg::APP_W-1:0]     in_app;
    logic [plra_pkg::MASK_W-1:0]    in_mask_f;
    logic [plra_pkg::REGION_W-1:0]  in_region;
    logic [plra_pkg::COLOR_W-1:0]   in_color;

    // Derived values.
    logic [AXW-1:0]                 app_x;
    logic                           app_ok;
    logic [AW-1:0]                  app_idx;
    logic [MXW-1:0]                 mask_x;
    logic [NR-1:0]                  in_mask;
    logic [RXW-1:0]                 region_x;
    logic [RXW-1:0]                 idx_x;
    logic                           region_ok;
    logic [RW-1:0]                  in_idx;
    logic [MXW-1:0]                 drv_x;
    logic [NR-1:0]                  drv_nr;
    logic [MXW-1:0]                 gbit_x;
    logic [MXW-1:0]                 grant_x;
    logic [DXW-1:0]                 walk_x;
    logic [RW-1:0]                  own_sel;
    logic [AW-1:0]                  own;
    logic                           out_free;
    logic                           accept;
    logic                           walk_last;
    logic                           color_drive;

    // Memory interface.
    plra_pkg::t_ram_ctl             ram_ctl;
    logic [ADDR_W-1:0]              ram_addr;
    logic [plra_pkg::COLOR_W-1:0]   ram_rdata;
    logic                           ram_ready;

    plra_color_ram #(
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ram_ctl),
        .i_addr  (ram_addr),
        .i_wdata (in_color),
        .o_rdata (ram_rdata),
        .o_ready (ram_ready)
    );

    // Field unpacking and range checks.
    assign in_app    = s_axis_tdata[2:0];
    assign in_mask_f = s_axis_tdata[10:3];
    assign in_region = s_axis_tdata[14:11];
    assign in_color  = s_axis_tdata[38:15];

    assign app_x     = AXW'(in_app);
    assign app_ok    = 32'(app_x) < 32'(NUM_APPS);
    assign app_idx   = app_x[AW-1:0];
    assign mask_x    = MXW'(in_mask_f);
    assign in_mask   = mask_x[NR-1:0];
    assign region_x  = RXW'(in_region);
    assign idx_x     = region_x - RXW'(1);
    assign region_ok = (in_region != '0) && (32'(in_region) <= 32'(NUM_REGIONS));
    assign in_idx    = idx_x[RW-1:0];
    assign drv_x     = MXW'(r_drv);
    assign drv_nr    = drv_x[NR-1:0];
    assign gbit_x    = MXW'(1) << in_idx;
    assign grant_x   = MXW'(r_grant);
    assign walk_x    = DXW'(r_region);
    assign walk_last = r_region == RW'(NUM_REGIONS - 1);

    // Owner search: highest application above zero whose claim holds the selected region, else zero.
    assign own_sel = (r_state == plra_pkg::S_IDLE) ? in_idx : r_region;

    always_comb begin
        own = '0;
        for (int a = 1; a < NUM_APPS; a++) begin
            if (r_claim[a][own_sel]) begin
                own = AW'(a);
            end
        end
    end

    assign color_drive = (own == app_idx) && drv_nr[in_idx];

    // Handshake.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == plra_pkg::S_IDLE) && ram_ready && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Sequencer: next state, memory strobes and result loading.
    always_comb begin
        n_state      = r_state;
        n_claim      = r_claim;
        n_app        = r_app;
        n_changed    = r_changed;
        n_grant      = r_grant;
        n_region     = r_region;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_user   = r_out_user;
        n_out_region = r_out_region;
        n_out_color  = r_out_color;
        n_out_grant  = r_out_grant;
        n_out_last   = r_out_last;
        ram_ctl      = '0;
        ram_addr     = {app_idx, in_idx};

        case (r_state)
            plra_pkg::S_IDLE: begin
                if (accept) begin
                    // Default closing result with every field zero.
                    n_out_valid  = 1'b1;
                    n_out_user   = 1'b0;
                    n_out_region = '0;
                    n_out_color  = '0;
                    n_out_grant  = '0;
                    n_out_last   = 1'b1;
                    if (app_ok && (s_axis_tuser == plra_pkg::MODE_CLAIM)) begin
                        // Replace the claim and start the region walk.
                        n_out_valid      = r_out_valid && !m_axis_tready;
                        n_claim[app_idx] = in_mask;
                        n_changed        = r_claim[app_idx] ^ in_mask;
                        n_app            = app_idx;
                        n_grant          = '0;
                        n_region         = '0;
                        n_state          = plra_pkg::S_WALK;
                    end else if (app_ok && region_ok) begin
                        // Cache the color; drive it if the caller owns the region and its driver is present.
                        ram_ctl.wr = 1'b1;
                        if (color_drive) begin
                            n_out_user   = 1'b1;
                            n_out_region = idx_x[plra_pkg::DREG_W-1:0];
                            n_out_color  = in_color;
                            n_out_grant  = gbit_x[plra_pkg::MASK_W-1:0];
                        end
                    end
                end
            end

            plra_pkg::S_WALK: begin
                ram_addr = {own, r_region};
                if (own <= r_app) begin
                    if (own == r_app) begin
                        n_grant[r_region] = r_claim[r_app][r_region];
                    end
                end
                if ((own <= r_app) && r_changed[r_region] && drv_nr[r_region]) begin
                    ram_ctl.rd = 1'b1;
                    n_state    = plra_pkg::S_READ;
                end else if (walk_last) begin
                    n_state = plra_pkg::S_LAST;
                end else begin
                    n_region = r_region + RW'(1);
                end
            end

            plra_pkg::S_READ: begin
                // The owner's cached color is on the read port; send it when the slot frees.
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_user   = 1'b1;
                    n_out_region = walk_x[plra_pkg::DREG_W-1:0];
                    n_out_color  = ram_rdata;
                    n_out_grant  = '0;
                    n_out_last   = 1'b0;
                    if (walk_last) begin
                        n_state = plra_pkg::S_LAST;
                    end else begin
                        n_region = r_region + RW'(1);
                        n_state  = plra_pkg::S_WALK;
                    end
                end
            end

            plra_pkg::S_LAST: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_user   = 1'b0;
                    n_out_region = '0;
                    n_out_color  = '0;
                    n_out_grant  = grant_x[plra_pkg::MASK_W-1:0];
                    n_out_last   = 1'b1;
                    n_state      = plra_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = plra_pkg::S_IDLE;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plra_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_drv       <= plra_pkg::DRV_RESET;
            for (int a = 0; a < NUM_APPS; a++) begin
                r_claim[a] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_claim     <= n_claim;
            if (i_cfg_wr_en) begin
                r_drv <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_app        <= n_app;
        r_changed    <= n_changed;
        r_grant      <= n_grant;
        r_region     <= n_region;
        r_out_user   <= n_out_user;
        r_out_region <= n_out_region;
        r_out_color  <= n_out_color;
        r_out_grant  <= n_out_grant;
        r_out_last   <= n_out_last;
    end

    // Result packing.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {5'b0, r_out_grant, r_out_color, r_out_region};

endmodule

>>> rtl/plra_checker.sv
// Port-level checker for the LED region arbiter, bound to the top level.
// Depends on plra_pkg and the assertion macros in priority_led_region_arbiter_unit_assert.svh.
`include "priority_led_region_arbiter_unit_assert.svh"

module plra_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [plra_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tuser,
    input logic                             m_axis_tlast
);

    // A stalled result keeps its contents.
    `PLRA_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

    // A result that drives nothing carries no region and no color.
    `PLRA_ASSERT(a_idle_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[26:0] == 27'd0, "non-drive result has region or color")

    // Only drives precede the closing result, and they carry no grant.
    `PLRA_ASSERT(a_mid_drive, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser && (m_axis_tdata[34:27] == 8'd0), "non-closing result is not a plain drive")

    // Right after reset no transfer is possible on either side while the cache clears.
    `PLRA_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !s_axis_tready && !m_axis_tvalid, "transfer possible right after reset")

endmodule

bind priority_led_region_arbiter_unit plra_checker u_plra_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
